[design/bfd_pkg.sv]
// bitmap frame deframer shared types and constants
package bfd_pkg;

  localparam int unsigned HdrLen   = 12;
  localparam int unsigned MagicLen = 4;

  typedef enum logic [1:0] {
    StatusPayload  = 2'd0,
    StatusBadMagic = 2'd1,
    StatusBadSize  = 2'd2,
    StatusAbort    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CfgFrameMagic  = 2'd0,
    CfgPanelWidth  = 2'd1,
    CfgPanelHeight = 2'd2,
    CfgRefreshEvery = 2'd3
  } cfg_index_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] pixel_byte;
    logic       last_of_frame;
    logic       full_refresh;
  } out_beat_t;

  localparam logic [31:0] MagicReset    = 32'h4B4E4945;
  localparam logic [15:0] WidthReset    = 16'd800;
  localparam logic [15:0] HeightReset   = 16'd480;
  localparam logic [7:0]  RefreshReset  = 8'd10;

endpackage

[design/bitmap_frame_deframer.sv]
// bitmap frame deframer: header parse, size check, payload inversion
// a result is registered in the output register, or in the skid stage when the output stalls
// throughput: one byte per cycle while the skid stage is empty; the payload length
// product is a registered 13x16 multiply that settles during the last two header bytes
// a two-entry output register and skid stage decouple the output stall
// reset: config registers take their defaults, parser returns to header phase
module bitmap_frame_deframer
  import bfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  pixel_byte_o,
  output logic        last_of_frame_o,
  output logic        full_refresh_o
);

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhPayload = 2'd1;
  localparam logic [1:0] PhDiscard = 2'd2;

  localparam logic [3:0] HdrLast  = 4'(HdrLen - 1);
  localparam logic [3:0] MagicEnd = 4'(MagicLen);

  // config registers
  logic [31:0] frame_magic_q;
  logic [15:0] panel_width_q;
  logic [15:0] panel_height_q;
  logic [7:0]  refresh_every_q;

  // parser state
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic        magic_ok_q, magic_ok_d;
  logic        size_hi_q, size_hi_d;
  logic [15:0] rx_width_q, rx_width_d;
  logic [15:0] rx_height_q, rx_height_d;
  logic [28:0] remain_q, remain_d;
  logic [7:0]  refresh_q, refresh_d;
  logic [28:0] frame_len_q;

  // output register and skid
  logic        out_valid_q;
  out_beat_t   out_q;
  logic        skid_valid_q;
  out_beat_t   skid_q;

  logic        in_fire;
  logic        out_fire;
  logic        res_valid;
  out_beat_t   res;
  logic [7:0]  want_byte;
  logic        byte_match;
  logic [8:0]  period;
  logic [8:0]  refresh_next;
  logic        size_ok;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_magic_q   <= MagicReset;
      panel_width_q   <= WidthReset;
      panel_height_q  <= HeightReset;
      refresh_every_q <= RefreshReset;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgFrameMagic:   frame_magic_q   <= cfg_data_i;
        CfgPanelWidth:   panel_width_q   <= cfg_data_i[15:0];
        CfgPanelHeight:  panel_height_q  <= cfg_data_i[15:0];
        CfgRefreshEvery: refresh_every_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (hdr_cnt_q[1:0])
      2'd0:    want_byte = frame_magic_q[7:0];
      2'd1:    want_byte = frame_magic_q[15:8];
      2'd2:    want_byte = frame_magic_q[23:16];
      default: want_byte = frame_magic_q[31:24];
    endcase
  end

  assign byte_match   = (data_byte_i == want_byte);
  assign period       = (refresh_every_q == 8'd0) ? 9'd1 : {1'b0, refresh_every_q};
  assign refresh_next = {1'b0, refresh_q} + 9'd1;
  // the last header byte is the top height byte, which must be zero
  assign size_ok      = !size_hi_q && (data_byte_i == 8'd0) &&
                        (rx_width_q == panel_width_q) && (rx_height_q == panel_height_q);

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    magic_ok_d  = magic_ok_q;
    size_hi_d   = size_hi_q;
    rx_width_d  = rx_width_q;
    rx_height_d = rx_height_q;
    remain_d    = remain_q;
    refresh_d   = refresh_q;
    res_valid   = 1'b0;
    res         = '{status: StatusPayload, pixel_byte: 8'd0,
                    last_of_frame: 1'b0, full_refresh: 1'b0};

    if (mode_i) begin
      if (phase_q == PhPayload) begin
        res_valid  = 1'b1;
        res.status = StatusAbort;
      end
      phase_d    = PhHeader;
      hdr_cnt_d  = 4'd0;
      magic_ok_d = 1'b1;
      size_hi_d  = 1'b0;
      remain_d   = '0;
    end else if (phase_q == PhDiscard) begin
      phase_d = PhDiscard;
    end else if (phase_q == PhPayload) begin
      res_valid      = 1'b1;
      res.pixel_byte = ~data_byte_i;
      if (remain_q > 29'd1) begin
        remain_d = remain_q - 29'd1;
      end else begin
        res.last_of_frame = 1'b1;
        res.full_refresh  = (refresh_q == 8'd0);
        refresh_d  = (refresh_next >= period) ? 8'd0 : refresh_next[7:0];
        remain_d   = '0;
        phase_d    = PhHeader;
        hdr_cnt_d  = 4'd0;
        magic_ok_d = 1'b1;
        size_hi_d  = 1'b0;
      end
    end else begin
      // header phase, unused code behaves the same
      hdr_cnt_d = hdr_cnt_q + 4'd1;
      case (hdr_cnt_q)
        4'd0, 4'd1, 4'd2, 4'd3: begin
          if (!byte_match) magic_ok_d = 1'b0;
        end
        4'd4:  rx_width_d[7:0]   = data_byte_i;
        4'd5:  rx_width_d[15:8]  = data_byte_i;
        4'd8:  rx_height_d[7:0]  = data_byte_i;
        4'd9:  rx_height_d[15:8] = data_byte_i;
        default: begin
          if (data_byte_i != 8'd0) size_hi_d = 1'b1;
        end
      endcase
      if (hdr_cnt_q >= HdrLast) begin
        hdr_cnt_d  = 4'd0;
        magic_ok_d = 1'b1;
        size_hi_d  = 1'b0;
        if (!magic_ok_q) begin
          phase_d    = PhDiscard;
          res_valid  = 1'b1;
          res.status = StatusBadMagic;
        end else if (!size_ok) begin
          phase_d    = PhDiscard;
          res_valid  = 1'b1;
          res.status = StatusBadSize;
        end else begin
          remain_d = frame_len_q;
          phase_d  = (frame_len_q != 29'd0) ? PhPayload : PhHeader;
        end
      end else if (hdr_cnt_q < MagicEnd) begin
        phase_d = PhHeader;
      end
    end
  end

  // both halves of width and height are final two beats before the header ends
  always_ff @(posedge clk_i) begin
    frame_len_q <= 29'(rx_width_q[15:3] * rx_height_q);
    rx_width_q  <= in_fire ? rx_width_d : rx_width_q;
    rx_height_q <= in_fire ? rx_height_d : rx_height_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      hdr_cnt_q  <= 4'd0;
      magic_ok_q <= 1'b1;
      size_hi_q  <= 1'b0;
      remain_q   <= '0;
      refresh_q  <= 8'd0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      magic_ok_q <= magic_ok_d;
      size_hi_q  <= size_hi_d;
      remain_q   <= remain_d;
      refresh_q  <= refresh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= in_fire && res_valid;
    end else if (in_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (!out_valid_q || out_fire) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign pixel_byte_o    = out_q.pixel_byte;
  assign last_of_frame_o = out_q.last_of_frame;
  assign full_refresh_o  = out_q.full_refresh;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output register is empty");

  a_payload_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (remain_q != 29'd0))
    else $error("payload phase with no bytes remaining");

  a_last_is_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last_of_frame) |-> (out_q.status == StatusPayload))
    else $error("end of frame marked on an error beat");

  a_error_no_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != StatusPayload)) |-> (out_q.pixel_byte == 8'd0))
    else $error("error beat carries pixel data");

endmodule
